// ===== rtl/lcp_pkg.sv =====
package lcp_pkg;

   localparam logic [2:0] OP_TOUCH_ENTER = 3'd0;
   localparam logic [2:0] OP_TOUCH_LEAVE = 3'd1;
   localparam logic [2:0] OP_LOCK_REQ    = 3'd2;
   localparam logic [2:0] OP_LOCK_DONE   = 3'd3;
   localparam logic [2:0] OP_UNLOCK      = 3'd4;
   localparam logic [2:0] OP_REPORT      = 3'd5;

   localparam int WORDS_GLOBAL = 11;
   localparam int WORDS_PATH   = 14;
   localparam int WORDS_TOTAL  = 39;
   localparam logic [5:0] LAST_WORD = 6'd38;

   localparam logic [31:0] WAIT_LIM0 = 32'd10;
   localparam logic [31:0] WAIT_LIM1 = 32'd100;
   localparam logic [31:0] WAIT_LIM2 = 32'd1000;
   localparam logic [31:0] WAIT_LIM3 = 32'd5000;
   localparam logic [31:0] WAIT_LIM4 = 32'd10000;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  task_req;
      logic [31:0] mutex_id;
      logic [31:0] now_us;
      logic [31:0] wait_us;
      logic        ok;
      logic        req_path;
      logic [7:0]  req_owner;
      logic        req_owner_path;
   } req_type;

   typedef struct packed {
      logic        is_target;
      logic        path;
      logic [7:0]  owner_id;
      logic        owner_side;
      logic [5:0]  word_index;
      logic [63:0] word_value;
      logic        last;
   } rsp_type;

   // per-path metric set
   typedef struct packed {
      logic [31:0]      call_count;
      logic [31:0]      error_count;
      logic [63:0]      wait_sum;
      logic [31:0]      wait_peak;
      logic [4:0][31:0] wait_bkt;
      logic [63:0]      hold_sum;
      logic [31:0]      hold_peak;
      logic [2:0][31:0] hold_bkt;
   } path_stats_type;

   // global state snapshot for report words 0..10
   typedef struct packed {
      logic [31:0] target_lock;
      logic [31:0] discovered_count;
      logic [7:0]  holder_task;
      logic        holder_path;
      logic [31:0] worst_wait;
      logic [7:0]  worst_waiter;
      logic        worst_waiter_path;
      logic [7:0]  worst_blocker;
      logic        worst_blocker_path;
      logic [31:0] unknown_owner_count;
      logic [31:0] mismatch_count;
   } glob_stats_type;

endpackage

// ===== rtl/lock_contention_profiler.sv =====
// A single-result request passes through the input register and then the output register before its response shows.
// Throughput: one request per cycle for touch, lock and unlock events while no report runs and the skid slot is free.
// A report holds the input while its 39 words stream out.
// Input register feeds combinational update logic; a full output stage holds it.
// Reset (synchronous, active high) clears all statistics and tracking state.
module lock_contention_profiler #(
   parameter int TASK_ID_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lcp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lcp_pkg::rsp_type  rsp_data
);

   localparam logic [7:0] TMASK = 8'((64'd1 << TASK_ID_BITS) - 64'd1);

   // input register
   logic             in_v_ff, in_v_in;
   lcp_pkg::req_type in_ff, in_in;

   logic [7:0]  touch_owner_ff, touch_owner_in, disc_owner_ff, disc_owner_in;
   logic [31:0] touch_nest_ff, touch_nest_in, disc_nest_ff, disc_nest_in;
   lcp_pkg::glob_stats_type g_ff, g_in;
   logic [31:0] holder_since_ff, holder_since_in;
   lcp_pkg::path_stats_type [1:0] st_ff, st_in;

   logic busy, start, single;
   lcp_pkg::rsp_type srsp;

   // hold off while a report runs, the skid slot is full, or a report is sitting in the input register
   logic rep_pending;
   assign rep_pending = in_v_ff && (in_ff.op == lcp_pkg::OP_REPORT);
   assign req_ready   = !busy && !rep_pending;

   // hold the request while a report runs or the output stage is full
   always_comb begin
      in_v_in = in_v_ff;
      in_in   = in_ff;
      if (!in_v_ff || !busy) begin
         in_v_in = req_valid && req_ready;
         in_in   = req_data;
      end
   end

   logic [7:0]  tsk, rown;
   logic        tgt, disc, rp, hp;
   logic [31:0] w, hold;

   always_comb begin
      tsk  = in_ff.task_req & TMASK;
      rown = in_ff.req_owner & TMASK;
      w    = in_ff.wait_us;
      rp   = in_ff.req_path;
      hp   = g_ff.holder_path;
      hold = in_ff.now_us - holder_since_ff;
      tgt  = (g_ff.target_lock != 0) && (in_ff.mutex_id == g_ff.target_lock);
      disc = (g_ff.target_lock == 0) && (in_ff.mutex_id != 0)
             && (disc_nest_ff != 0) && (disc_owner_ff == tsk);

      touch_owner_in  = touch_owner_ff;
      touch_nest_in   = touch_nest_ff;
      disc_owner_in   = disc_owner_ff;
      disc_nest_in    = disc_nest_ff;
      g_in            = g_ff;
      holder_since_in = holder_since_ff;
      st_in           = st_ff;
      single          = 1'b0;
      start           = 1'b0;
      srsp            = '0;
      srsp.last       = 1'b1;

      if (in_v_ff && !busy) begin
         case (in_ff.op)
            lcp_pkg::OP_TOUCH_ENTER: begin
               single = 1'b1;
               if (touch_nest_ff == 0 || touch_owner_ff == tsk) begin
                  touch_owner_in = tsk;
                  touch_nest_in  = touch_nest_ff + 32'd1;
               end
               if (g_ff.target_lock == 0) begin
                  disc_owner_in = tsk;
                  disc_nest_in  = disc_nest_ff + 32'd1;
               end
            end
            lcp_pkg::OP_TOUCH_LEAVE: begin
               single = 1'b1;
               if (touch_owner_ff == tsk && touch_nest_ff != 0) begin
                  touch_nest_in = touch_nest_ff - 32'd1;
                  if (touch_nest_ff == 32'd1) touch_owner_in = '0;
               end
               if (disc_owner_ff == tsk && disc_nest_ff != 0) begin
                  disc_nest_in = disc_nest_ff - 32'd1;
                  if (disc_nest_ff == 32'd1) disc_owner_in = '0;
               end
            end
            lcp_pkg::OP_LOCK_REQ: begin
               single = 1'b1;
               if (disc) begin
                  g_in.target_lock      = in_ff.mutex_id;
                  g_in.discovered_count = g_ff.discovered_count + 32'd1;
               end
               if (tgt || disc) begin
                  srsp.is_target  = 1'b1;
                  srsp.path       = (tsk != 0) && (tsk == touch_owner_ff)
                                    && (touch_nest_ff != 0);
                  srsp.owner_id   = g_ff.holder_task;
                  srsp.owner_side = g_ff.holder_path;
               end
            end
            lcp_pkg::OP_LOCK_DONE: begin
               single         = 1'b1;
               srsp.is_target = tgt;
               if (tgt && in_ff.ok) begin
                  st_in[rp].call_count = st_ff[rp].call_count + 32'd1;
                  st_in[rp].wait_sum   = st_ff[rp].wait_sum + {32'd0, w};
                  if (w > st_ff[rp].wait_peak) st_in[rp].wait_peak = w;
                  if (w >= lcp_pkg::WAIT_LIM0)
                     st_in[rp].wait_bkt[0] = st_ff[rp].wait_bkt[0] + 32'd1;
                  if (w >= lcp_pkg::WAIT_LIM1)
                     st_in[rp].wait_bkt[1] = st_ff[rp].wait_bkt[1] + 32'd1;
                  if (w >= lcp_pkg::WAIT_LIM2)
                     st_in[rp].wait_bkt[2] = st_ff[rp].wait_bkt[2] + 32'd1;
                  if (w >= lcp_pkg::WAIT_LIM3)
                     st_in[rp].wait_bkt[3] = st_ff[rp].wait_bkt[3] + 32'd1;
                  if (w >= lcp_pkg::WAIT_LIM4)
                     st_in[rp].wait_bkt[4] = st_ff[rp].wait_bkt[4] + 32'd1;
                  g_in.holder_task = tsk;
                  g_in.holder_path = rp;
                  holder_since_in  = in_ff.now_us;
                  if (w > g_ff.worst_wait) begin
                     g_in.worst_wait         = w;
                     g_in.worst_waiter       = tsk;
                     g_in.worst_blocker      = rown;
                     g_in.worst_waiter_path  = rp;
                     g_in.worst_blocker_path = in_ff.req_owner_path;
                  end
                  if (w >= lcp_pkg::WAIT_LIM1 && rown == 0)
                     g_in.unknown_owner_count = g_ff.unknown_owner_count + 32'd1;
               end else if (tgt) begin
                  st_in[rp].error_count = st_ff[rp].error_count + 32'd1;
               end
            end
            lcp_pkg::OP_UNLOCK: begin
               single         = 1'b1;
               srsp.is_target = tgt;
               if (tgt && g_ff.holder_task == tsk) begin
                  st_in[hp].hold_sum = st_ff[hp].hold_sum + {32'd0, hold};
                  if (hold > st_ff[hp].hold_peak) st_in[hp].hold_peak = hold;
                  if (hold >= lcp_pkg::WAIT_LIM2)
                     st_in[hp].hold_bkt[0] = st_ff[hp].hold_bkt[0] + 32'd1;
                  if (hold >= lcp_pkg::WAIT_LIM3)
                     st_in[hp].hold_bkt[1] = st_ff[hp].hold_bkt[1] + 32'd1;
                  if (hold >= lcp_pkg::WAIT_LIM4)
                     st_in[hp].hold_bkt[2] = st_ff[hp].hold_bkt[2] + 32'd1;
                  g_in.holder_task = '0;
                  holder_since_in  = '0;
               end else if (tgt) begin
                  g_in.mismatch_count = g_ff.mismatch_count + 32'd1;
               end
            end
            lcp_pkg::OP_REPORT: begin
               // snapshot goes to the sequencer; clear metrics
               start                    = 1'b1;
               st_in                    = '0;
               g_in.worst_wait          = '0;
               g_in.worst_waiter        = '0;
               g_in.worst_blocker       = '0;
               g_in.unknown_owner_count = '0;
               g_in.mismatch_count      = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff         <= 1'b0;
         touch_owner_ff  <= '0;
         touch_nest_ff   <= '0;
         disc_owner_ff   <= '0;
         disc_nest_ff    <= '0;
         g_ff            <= '0;
         holder_since_ff <= '0;
         st_ff           <= '0;
      end else begin
         in_v_ff         <= in_v_in;
         touch_owner_ff  <= touch_owner_in;
         touch_nest_ff   <= touch_nest_in;
         disc_owner_ff   <= disc_owner_in;
         disc_nest_ff    <= disc_nest_in;
         g_ff            <= g_in;
         holder_since_ff <= holder_since_in;
         st_ff           <= st_in;
      end
      in_ff <= in_in;
   end

   lcp_report u_report (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .single     (single),
      .single_rsp (srsp),
      .glob       (g_ff),
      .stats      (st_ff),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== rtl/lcp_report.sv =====
// Report sequencer: snapshots the statistics and emits 39 words, or passes on
// single results, through a two-entry output stage; the input is held while a
// report runs or once the overflow slot fills.
module lcp_report (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        single,
   input  lcp_pkg::rsp_type            single_rsp,
   input  lcp_pkg::glob_stats_type     glob,
   input  lcp_pkg::path_stats_type [1:0] stats,
   output logic                        busy,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output lcp_pkg::rsp_type            rsp_data
);

   lcp_pkg::glob_stats_type      glob_ff, glob_in;
   lcp_pkg::path_stats_type [1:0] stats_ff, stats_in;
   logic       run_ff, run_in;
   logic [5:0] idx_ff, idx_in;
   // skid stage: main output and overflow slot
   logic       out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   lcp_pkg::rsp_type out_ff, out_in, skid_ff, skid_in;

   logic             gen_v;
   lcp_pkg::rsp_type gen;
   logic [63:0]      wv;
   logic [5:0]       rel;
   logic             pth;
   logic [3:0]       j;

   // select report word
   always_comb begin
      wv  = '0;
      pth = 1'b0;
      rel = '0;
      j   = '0;
      case (idx_ff)
         6'd0:  wv = {32'd0, glob_ff.target_lock};
         6'd1:  wv = {32'd0, glob_ff.discovered_count};
         6'd2:  wv = {56'd0, glob_ff.holder_task};
         6'd3:  wv = {63'd0, glob_ff.holder_path};
         6'd4:  wv = {32'd0, glob_ff.worst_wait};
         6'd5:  wv = {56'd0, glob_ff.worst_waiter};
         6'd6:  wv = {63'd0, glob_ff.worst_waiter_path};
         6'd7:  wv = {56'd0, glob_ff.worst_blocker};
         6'd8:  wv = {63'd0, glob_ff.worst_blocker_path};
         6'd9:  wv = {32'd0, glob_ff.unknown_owner_count};
         6'd10: wv = {32'd0, glob_ff.mismatch_count};
         default: begin
            rel = idx_ff - 6'(lcp_pkg::WORDS_GLOBAL);
            pth = (rel >= 6'(lcp_pkg::WORDS_PATH));
            j   = pth ? 4'(rel - 6'(lcp_pkg::WORDS_PATH)) : rel[3:0];
            case (j)
               4'd0:  wv = {32'd0, stats_ff[pth].call_count};
               4'd1:  wv = {32'd0, stats_ff[pth].error_count};
               4'd2:  wv = stats_ff[pth].wait_sum;
               4'd3:  wv = {32'd0, stats_ff[pth].wait_peak};
               4'd4:  wv = {32'd0, stats_ff[pth].wait_bkt[0]};
               4'd5:  wv = {32'd0, stats_ff[pth].wait_bkt[1]};
               4'd6:  wv = {32'd0, stats_ff[pth].wait_bkt[2]};
               4'd7:  wv = {32'd0, stats_ff[pth].wait_bkt[3]};
               4'd8:  wv = {32'd0, stats_ff[pth].wait_bkt[4]};
               4'd9:  wv = stats_ff[pth].hold_sum;
               4'd10: wv = {32'd0, stats_ff[pth].hold_peak};
               4'd11: wv = {32'd0, stats_ff[pth].hold_bkt[0]};
               4'd12: wv = {32'd0, stats_ff[pth].hold_bkt[1]};
               4'd13: wv = {32'd0, stats_ff[pth].hold_bkt[2]};
               default: wv = '0;
            endcase
         end
      endcase
   end

   // pick the generated response: report word or single result
   always_comb begin
      gen   = single_rsp;
      gen_v = single;
      if (run_ff) begin
         gen_v           = 1'b1;
         gen             = '0;
         gen.word_index  = idx_ff;
         gen.word_value  = wv;
         gen.last        = (idx_ff == lcp_pkg::LAST_WORD);
      end
   end

   // the report walks only while the skid slot is free
   logic advance;
   assign advance = run_ff && !skid_v_ff;

   always_comb begin
      glob_in  = glob_ff;
      stats_in = stats_ff;
      run_in   = run_ff;
      idx_in   = idx_ff;
      if (start) begin
         glob_in  = glob;
         stats_in = stats;
         run_in   = 1'b1;
         idx_in   = '0;
      end else if (advance) begin
         idx_in = idx_ff + 6'd1;
         if (idx_ff == lcp_pkg::LAST_WORD) run_in = 1'b0;
      end
   end

   // output stage with skid slot
   logic push;
   assign push = run_ff ? advance : gen_v;

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (!out_v_ff || rsp_ready) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_in    = skid_ff;
            skid_v_in = 1'b0;
            if (push) begin
               skid_v_in = 1'b1;
               skid_in   = gen;
            end
         end else begin
            out_v_in = push;
            out_in   = gen;
         end
      end else if (push) begin
         skid_v_in = 1'b1;
         skid_in   = gen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         idx_ff    <= '0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         run_ff    <= run_in;
         idx_ff    <= idx_in;
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      glob_ff  <= glob_in;
      stats_ff <= stats_in;
      out_ff   <= out_in;
      skid_ff  <= skid_in;
   end

   assign busy      = run_ff || skid_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule
